FILE: hw/rtl/crc16_response_frame_checker_core_defines.svh
// ----------------------------------------------------------------------------
// CRC-16 response frame checker: assertion macros
// Shared property shorthands for the checker module.
// ----------------------------------------------------------------------------
`ifndef CRC16_RESPONSE_FRAME_CHECKER_CORE_DEFINES_SVH
`define CRC16_RESPONSE_FRAME_CHECKER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CRCFC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("crcfc: same-cycle property failed");

// Next-cycle implication, disabled while reset is asserted.
`define CRCFC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("crcfc: next-cycle property failed");

`endif

FILE: hw/rtl/crcfc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC-16 response frame checker package
// Types, status codes and constants shared by the checker modules.
// ----------------------------------------------------------------------------
package crcfc_pkg;

    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'hA001;
    localparam logic [7:0]  MIN_FRAME  = 8'd5;
    localparam int          CFG_IDX_W  = 2;

    typedef enum logic [2:0] {
        ST_OK   = 3'd0,
        ST_LEN  = 3'd1,
        ST_ADDR = 3'd2,
        ST_FUNC = 3'd3,
        ST_CRC  = 3'd4
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_LENGTH      = 2'd0,
        CFG_STATION_ADDRESS   = 2'd1,
        CFG_EXPECTED_FUNCTION = 2'd2
    } t_cfg_index;

    typedef struct packed {
        logic [7:0] frame_length;
        logic [7:0] station_address;
        logic [7:0] expected_function;
    } t_cfg;

    typedef struct packed {
        t_status     status;
        logic [15:0] computed_crc;
    } t_result;

endpackage

FILE: hw/rtl/crc16_response_frame_checker_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC-16 response frame checker
// Checks received response frames byte by byte and reports one verdict each.
// ----------------------------------------------------------------------------
// The core takes one received byte per item, at up to one item per clock.
// An item with the first flag set starts a new frame. Byte 0 is compared with
// the frame length register, byte 1 with the station address and byte 2 with
// the expected function code. A reflected CRC-16 (polynomial 0xA001, start
// value 0xFFFF) runs over every byte except the last two, which must carry
// the CRC low byte first. On the last byte of the frame one result item is
// produced with the first failing check (length, address, function, CRC, in
// that order of priority) and the computed CRC. Bytes after the verdict and
// before the next first flag are dropped, as are bytes before any first flag.
// A frame length below five is counted as five bytes. Each item is latched
// into an input register and folded into the frame state in the following
// cycle; a result then enters the result queue and is presented from its
// head. A two-entry result queue decouples the sides; the input stalls when
// that queue might not absorb another result, so with an unstalled output
// the core accepts one item every cycle. Configuration writes are always
// ready and take effect for bytes processed after the write; indexes beyond
// the register list are ignored.
// ----------------------------------------------------------------------------
module crc16_response_frame_checker_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Byte input channel.
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [7:0]                           i_rx_byte,
    input  logic                                 i_frame_first,
    // Verdict output channel.
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [2:0]                           o_status,
    output logic [15:0]                          o_computed_crc,
    // Configuration write channel.
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [crcfc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [7:0]                           i_cfg_data
);

    // Configuration registers.
    crcfc_pkg::t_cfg    r_cfg, n_cfg;

    // Input register stage.
    logic               r_in_valid;
    logic [7:0]         r_rx_byte;
    logic               r_frame_first;
    logic               in_accept;

    logic               res_valid;
    crcfc_pkg::t_result res;
    crcfc_pkg::t_result q_data;
    logic [1:0]         q_count;

    assign o_cfg_ready = 1'b1;

    // The write port never blocks; an unknown index leaves all registers alone.
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (crcfc_pkg::t_cfg_index'(i_cfg_index))
                crcfc_pkg::CFG_FRAME_LENGTH:      n_cfg.frame_length      = i_cfg_data;
                crcfc_pkg::CFG_STATION_ADDRESS:   n_cfg.station_address   = i_cfg_data;
                crcfc_pkg::CFG_EXPECTED_FUNCTION: n_cfg.expected_function = i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_length      <= crcfc_pkg::MIN_FRAME;
            r_cfg.station_address   <= 8'd2;
            r_cfg.expected_function <= 8'd0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // The item in the input register may still turn into a result, so it is
    // counted against the queue's free space unless the output takes the
    // queue head in the same cycle.
    assign o_in_stall = (q_count == 2'd2) || (q_count == 2'd1 && r_in_valid && i_out_stall);
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= in_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_rx_byte     <= i_rx_byte;
            r_frame_first <= i_frame_first;
        end
    end

    crcfc_frame u_frame (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (r_in_valid),
        .i_rx_byte     (r_rx_byte),
        .i_frame_first (r_frame_first),
        .i_cfg         (r_cfg),
        .o_res_valid   (res_valid),
        .o_res         (res)
    );

    crcfc_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (res_valid),
        .i_data      (res),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_data      (q_data),
        .o_count     (q_count)
    );

    assign o_status       = q_data.status;
    assign o_computed_crc = q_data.computed_crc;

endmodule

FILE: hw/rtl/crcfc_crc_byte.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC-16 byte update
// Folds one byte into a reflected CRC-16 (polynomial 0xA001).
// ----------------------------------------------------------------------------
module crcfc_crc_byte (
    input  logic [15:0] i_crc,
    input  logic [7:0]  i_data,
    output logic [15:0] o_crc
);

    always_comb begin
        logic [15:0] c;
        c = i_crc ^ {8'h00, i_data};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ crcfc_pkg::CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        o_crc = c;
    end

endmodule

FILE: hw/rtl/crcfc_frame.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame tracker
// Holds the per-frame state, checks header bytes and gives the verdict.
// ----------------------------------------------------------------------------
module crcfc_frame (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [7:0]         i_rx_byte,
    input  logic               i_frame_first,
    input  crcfc_pkg::t_cfg    i_cfg,
    output logic               o_res_valid,
    output crcfc_pkg::t_result o_res
);

    logic [7:0]         r_byte_count, n_byte_count;
    logic [15:0]        r_crc_accum,  n_crc_accum;
    crcfc_pkg::t_status r_first_error, n_first_error;
    logic [7:0]         r_crc_low,    n_crc_low;
    logic               r_frame_done, n_frame_done;

    logic [7:0]         cnt_b;
    logic [15:0]        crc_b;
    crcfc_pkg::t_status err_b;
    logic [7:0]         low_b;
    logic               done_b;
    logic [7:0]         len;
    logic [7:0]         len_m2;
    logic               is_last;
    logic [15:0]        crc_upd;
    crcfc_pkg::t_status cand;
    crcfc_pkg::t_status err_upd;

    crcfc_crc_byte u_crc (
        .i_crc  (crc_b),
        .i_data (i_rx_byte),
        .o_crc  (crc_upd)
    );

    always_comb begin
        // A first flag restarts the frame before the byte is looked at.
        cnt_b  = i_frame_first ? 8'd0 : r_byte_count;
        crc_b  = i_frame_first ? crcfc_pkg::CRC_INIT : r_crc_accum;
        err_b  = i_frame_first ? crcfc_pkg::ST_OK : r_first_error;
        low_b  = i_frame_first ? 8'd0 : r_crc_low;
        done_b = i_frame_first ? 1'b0 : r_frame_done;

        len     = (i_cfg.frame_length < crcfc_pkg::MIN_FRAME) ? crcfc_pkg::MIN_FRAME
                                                              : i_cfg.frame_length;
        len_m2  = len - 8'd2;
        is_last = (cnt_b > len_m2);

        if (cnt_b == 8'd0 && i_rx_byte != i_cfg.frame_length) begin
            cand = crcfc_pkg::ST_LEN;
        end else if (cnt_b == 8'd1 && i_rx_byte != i_cfg.station_address) begin
            cand = crcfc_pkg::ST_ADDR;
        end else if (cnt_b == 8'd2 && i_rx_byte != i_cfg.expected_function) begin
            cand = crcfc_pkg::ST_FUNC;
        end else if (is_last && (low_b != crc_b[7:0] || i_rx_byte != crc_b[15:8])) begin
            cand = crcfc_pkg::ST_CRC;
        end else begin
            cand = crcfc_pkg::ST_OK;
        end
        err_upd = (err_b != crcfc_pkg::ST_OK) ? err_b : cand;

        n_byte_count  = r_byte_count;
        n_crc_accum   = r_crc_accum;
        n_first_error = r_first_error;
        n_crc_low     = r_crc_low;
        n_frame_done  = r_frame_done;
        o_res_valid   = 1'b0;

        if (i_valid) begin
            n_byte_count  = cnt_b;
            n_crc_accum   = crc_b;
            n_first_error = err_b;
            n_crc_low     = low_b;
            n_frame_done  = done_b;
            if (!done_b) begin
                n_first_error = err_upd;
                if (cnt_b < len_m2) begin
                    n_crc_accum = crc_upd;
                end else if (cnt_b == len_m2) begin
                    n_crc_low = i_rx_byte;
                end
                if (is_last) begin
                    n_frame_done = 1'b1;
                    o_res_valid  = 1'b1;
                end else begin
                    n_byte_count = cnt_b + 8'd1;
                end
            end
        end

        o_res.status       = err_upd;
        o_res.computed_crc = crc_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count  <= 8'd0;
            r_crc_accum   <= crcfc_pkg::CRC_INIT;
            r_first_error <= crcfc_pkg::ST_OK;
            r_crc_low     <= 8'd0;
            r_frame_done  <= 1'b1;
        end else begin
            r_byte_count  <= n_byte_count;
            r_crc_accum   <= n_crc_accum;
            r_first_error <= n_first_error;
            r_crc_low     <= n_crc_low;
            r_frame_done  <= n_frame_done;
        end
    end

endmodule

FILE: hw/rtl/crcfc_outq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result queue
// Two-entry output register with skid slot; reports its fill level.
// ----------------------------------------------------------------------------
module crcfc_outq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  crcfc_pkg::t_result i_data,
    input  logic               i_out_stall,
    output logic               o_out_valid,
    output crcfc_pkg::t_result o_data,
    output logic [1:0]         o_count
);

    logic [1:0]         r_cnt, n_cnt;
    crcfc_pkg::t_result r_head, n_head;
    crcfc_pkg::t_result r_tail, n_tail;
    logic               pop;

    always_comb begin
        pop    = (r_cnt != 2'd0) && !i_out_stall;
        n_cnt  = r_cnt;
        n_head = r_head;
        n_tail = r_tail;
        case ({i_push, pop})
            2'b11: begin
                if (r_cnt == 2'd1) begin
                    n_head = i_data;
                end else begin
                    n_head = r_tail;
                    n_tail = i_data;
                end
            end
            2'b10: begin
                if (r_cnt == 2'd0) begin
                    n_head = i_data;
                end else begin
                    n_tail = i_data;
                end
                n_cnt = r_cnt + 2'd1;
            end
            2'b01: begin
                n_head = r_tail;
                n_cnt  = r_cnt - 2'd1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_head <= n_head;
        r_tail <= n_tail;
    end

    assign o_out_valid = (r_cnt != 2'd0);
    assign o_data      = r_head;
    assign o_count     = r_cnt;

endmodule

FILE: hw/rtl/crcfc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC-16 response frame checker: port checker
// Concurrent assertions on the core's ports, bound to the top level.
// ----------------------------------------------------------------------------
`include "crc16_response_frame_checker_core_defines.svh"

module crcfc_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input logic                             o_in_stall,
    input logic                             o_out_valid,
    input logic                             i_out_stall,
    input logic [2:0]                       o_status,
    input logic [15:0]                      o_computed_crc
);

    // A waiting result holds until it is taken.
    `CRCFC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_status) && $stable(o_computed_crc))

    // Only the five defined verdict codes are ever reported.
    `CRCFC_ASSERT_IMPLY(a_status_range, i_clk, i_rst_n, o_out_valid, o_status <= 3'd4)

    // The input only stalls while a result is waiting on the output.
    `CRCFC_ASSERT_IMPLY(a_stall_cause, i_clk, i_rst_n, o_in_stall, o_out_valid)

    // A result on an empty output stems from a byte in the input register.
    `CRCFC_ASSERT_IMPLY(a_result_latency, i_clk, i_rst_n, $rose(o_out_valid), $past(i_in_valid && !o_in_stall, 2))

endmodule

bind crc16_response_frame_checker_core crcfc_checker u_crcfc_checker (.*);

FILE: test/tb_crc16_response_frame_checker_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC-16 response frame checker testbench
// The testbench streams response frames into the checker and compares every
// verdict with a frame-level predictor of its own.
// ----------------------------------------------------------------------------
// A short table of frames runs first, with the reset register values. It
// covers a byte before any first flag, a good frame, each of the four
// failure codes, and a frame that is dropped by a new first flag. Its
// verdict status is typed into the table. Random phases follow. Each phase
// writes the three registers while the checker is idle, among them the
// lengths 255 and 0 and the spare index that the checker must ignore. It
// then sends mostly well-formed frames with random content. The rest are
// frames with one field broken, cut-short frames, garbage frames and stray
// bytes. The phases rotate through four idling patterns on the two sides.
// ----------------------------------------------------------------------------
module tb_crc16_response_frame_checker_core;
    import crcfc_pkg::*;

    // The index one past the register list, which the checker ignores.
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

    // How a table row gets its data byte. A plain byte is folded into the
    // frame CRC that the table builds, a held byte is sent as written and
    // left out of that CRC, and the CRC kinds send the CRC built so far, the bad kind with one bit flipped.
    typedef enum logic [2:0] {
        BK_RAW,
        BK_HOLD,
        BK_CRC_LO,
        BK_CRC_HI,
        BK_CRC_HI_BAD
    } t_byte_kind;

    typedef struct packed {
        t_byte_kind  kind;
        logic [7:0]  rx;
        logic        first;
        logic        pin;
        t_status     status;
    } t_stim_row;

    // The table runs with the reset values: length 5, address 2, function 0.
    localparam int STIM_ROWS = 28;
    localparam t_stim_row STIM_TAB [STIM_ROWS] = '{
        // A byte before any first flag is dropped.
        '{BK_HOLD,       8'h55, 1'b0, 1'b0, ST_OK},
        // A good frame.
        '{BK_RAW,        8'h05, 1'b1, 1'b0, ST_OK},
        '{BK_RAW,        8'h02, 1'b0, 1'b0, ST_OK},
        '{BK_RAW,        8'h00, 1'b0, 1'b0, ST_OK},
        '{BK_CRC_LO,     8'h00, 1'b0, 1'b0, ST_OK},
        '{BK_CRC_HI,     8'h00, 1'b0, 1'b1, ST_OK},
        // Every check fails, and the length failure wins.
        '{BK_RAW,        8'hFF, 1'b1, 1'b0, ST_OK},
        '{BK_RAW,        8'hFF, 1'b0, 1'b0, ST_OK},
        '{BK_RAW,        8'hFF, 1'b0, 1'b0, ST_OK},
        '{BK_HOLD,       8'h00, 1'b0, 1'b0, ST_OK},
        '{BK_HOLD,       8'h00, 1'b0, 1'b1, ST_LEN},
        // Address and function are wrong, and the address failure wins.
        '{BK_RAW,        8'h05, 1'b1, 1'b0, ST_OK},
        '{BK_RAW,        8'h00, 1'b0, 1'b0, ST_OK},
        '{BK_RAW,        8'hFF, 1'b0, 1'b0, ST_OK},
        '{BK_CRC_LO,     8'h00, 1'b0, 1'b0, ST_OK},
        '{BK_CRC_HI,     8'h00, 1'b0, 1'b1, ST_ADDR},
        // A frame cut short by the next first flag gives no verdict.
        '{BK_RAW,        8'h05, 1'b1, 1'b0, ST_OK},
        '{BK_RAW,        8'h02, 1'b0, 1'b0, ST_OK},
        // Wrong function code.
        '{BK_RAW,        8'h05, 1'b1, 1'b0, ST_OK},
        '{BK_RAW,        8'h02, 1'b0, 1'b0, ST_OK},
        '{BK_RAW,        8'h01, 1'b0, 1'b0, ST_OK},
        '{BK_CRC_LO,     8'h00, 1'b0, 1'b0, ST_OK},
        '{BK_CRC_HI,     8'h00, 1'b0, 1'b1, ST_FUNC},
        // Wrong CRC high byte.
        '{BK_RAW,        8'h05, 1'b1, 1'b0, ST_OK},
        '{BK_RAW,        8'h02, 1'b0, 1'b0, ST_OK},
        '{BK_RAW,        8'h00, 1'b0, 1'b0, ST_OK},
        '{BK_CRC_LO,     8'h00, 1'b0, 1'b0, ST_OK},
        '{BK_CRC_HI_BAD, 8'h00, 1'b0, 1'b1, ST_CRC}
    };

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [7:0]            i_rx_byte;
    logic                  i_frame_first;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [2:0]            o_status;
    logic [15:0]           o_computed_crc;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [7:0]            i_cfg_data;

    crc16_response_frame_checker_core uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_rx_byte      (i_rx_byte),
        .i_frame_first  (i_frame_first),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_computed_crc (o_computed_crc),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // Register values as the checker should hold them, updated when a write
    // is accepted. The frame generator reads them too.
    logic [7:0]  cfg_len;
    logic [7:0]  cfg_addr;
    logic [7:0]  cfg_func;

    // Frame state of the predictor.
    logic [7:0]  frame_pos;
    logic [15:0] frame_crc;
    t_status     frame_err;
    logic [7:0]  crc_lo_held;
    logic        frame_closed;

    // Verdicts predicted but not yet seen on the output.
    t_result     verdict_q[$];

    // A typed-in status travels with the item and holds with its payload.
    logic        pin_valid;
    t_status     pin_status;

    int          in_idle_pct;
    int          out_stall_pct;
    int          err_count;
    int          counted_bytes;
    int          verdicts_due;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Generous limit: several times the slowest correct run.
    initial begin
        #(4_000_000);
        $display("CHECK FAILED");
        $finish;
    end

    // The output side stalls at random at the rate of the current phase.
    always @(negedge i_clk) begin
        i_out_stall <= (out_stall_pct != 0) && ($urandom_range(99) < out_stall_pct);
    end

    // Reflected CRC-16 over one byte, least significant bit first.
    function automatic logic [15:0] crc16_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // Folds one accepted byte into the predicted frame state. A verdict is
    // returned on the last byte of a frame.
    task automatic frame_fold(input logic [7:0] rx, input logic first,
                              output logic got, output t_result v);
        int unsigned span;
        int unsigned pos;
        got = 1'b0;
        v = '0;
        if (first) begin
            frame_pos = 8'd0;
            frame_crc = CRC_INIT;
            frame_err = ST_OK;
            crc_lo_held = 8'd0;
            frame_closed = 1'b0;
        end
        if (!frame_closed) begin
            // Short length settings are counted as the minimum frame, while
            // byte 0 is still compared with the register as written.
            span = 32'((cfg_len < MIN_FRAME) ? MIN_FRAME : cfg_len);
            pos = 32'(frame_pos);
            if (pos == 0 && rx != cfg_len && frame_err == ST_OK) frame_err = ST_LEN;
            if (pos == 1 && rx != cfg_addr && frame_err == ST_OK) frame_err = ST_ADDR;
            if (pos == 2 && rx != cfg_func && frame_err == ST_OK) frame_err = ST_FUNC;
            if (pos < span - 2) begin
                frame_crc = crc16_fold(frame_crc, rx);
            end else if (pos == span - 2) begin
                crc_lo_held = rx;
            end
            if (pos >= span - 1) begin
                if ((crc_lo_held != frame_crc[7:0] || rx != frame_crc[15:8])
                        && frame_err == ST_OK) begin
                    frame_err = ST_CRC;
                end
                v.status = frame_err;
                v.computed_crc = frame_crc;
                got = 1'b1;
                frame_closed = 1'b1;
            end else begin
                frame_pos = frame_pos + 8'd1;
            end
        end
    endtask

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("%0t mismatch: %s got %h want %h", $time, what, got, want);
        err_count++;
    endtask

    // Everything seen on the ports is taken at the rising edge, before the
    // checker's own registers move.
    always @(posedge i_clk) begin
        logic    got;
        t_result v;
        t_result want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_FRAME_LENGTH:      cfg_len = i_cfg_data;
                    CFG_STATION_ADDRESS:   cfg_addr = i_cfg_data;
                    CFG_EXPECTED_FUNCTION: cfg_func = i_cfg_data;
                    default: ;
                endcase
            end
            if (o_out_valid && !i_out_stall) begin
                if (verdict_q.size() == 0) begin
                    report_mismatch("verdict with none due, status/crc",
                                    {13'd0, o_status}, o_computed_crc);
                end else begin
                    want = verdict_q.pop_front();
                    if (o_status != want.status) begin
                        report_mismatch("status", {13'd0, o_status}, {13'd0, want.status});
                    end
                    if (o_computed_crc != want.computed_crc) begin
                        report_mismatch("computed_crc", o_computed_crc, want.computed_crc);
                    end
                end
            end
            if (i_in_valid && !o_in_stall) begin
                frame_fold(i_rx_byte, i_frame_first, got, v);
                if (got) begin
                    if (pin_valid) v.status = pin_status;
                    verdict_q.push_back(v);
                    verdicts_due++;
                end
            end
        end
    end

    // Offers one item, after a random gap when the sender idles, and
    // returns at the edge where it is accepted. Valid stays high so that a
    // following item can go out without a gap.
    task automatic send_byte(input logic [7:0] rx, input logic first,
                             input logic pin, input t_status pin_st);
        @(negedge i_clk);
        if (in_idle_pct != 0 && $urandom_range(99) < in_idle_pct) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 2)) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_rx_byte = rx;
        i_frame_first = first;
        pin_valid = pin;
        pin_status = pin_st;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Registers change only when no verdict is pending. A last byte that
    // gives no verdict may still sit in the input register, so the task waits
    // on past an empty verdict queue before the next write.
    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    // Sends one frame for the current registers. Most frames are
    // well-formed, some with one field broken; the rest are cut short,
    // garbage, or stray bytes with no first flag.
    task automatic send_frame(input logic clean);
        logic [7:0]  fb [0:254];
        logic [15:0] crc;
        int          span;
        int          roll;
        int          n;
        int          broken;
        span = int'((cfg_len < MIN_FRAME) ? MIN_FRAME : cfg_len);
        roll = clean ? 99 : $urandom_range(99);
        if (roll < 12) begin
            // Stray bytes: dropped after a verdict.
            repeat ($urandom_range(1, 3)) begin
                send_byte(8'($urandom_range(255)), 1'b0, 1'b0, ST_OK);
            end
        end else if (roll < 32) begin
            // A cut-short frame keeps the right first byte, and a garbage
            // frame has every byte random.
            n = (roll < 24) ? $urandom_range(1, span - 1) : span;
            for (int k = 0; k < n; k++) begin
                fb[k] = (k == 0 && roll < 24) ? cfg_len : 8'($urandom_range(255));
                send_byte(fb[k], k == 0, 1'b0, ST_OK);
            end
            counted_bytes += n;
        end else begin
            fb[0] = cfg_len;
            fb[1] = cfg_addr;
            fb[2] = cfg_func;
            crc = CRC_INIT;
            for (int k = 0; k < span - 2; k++) begin
                if (k > 2) fb[k] = 8'($urandom_range(255));
                crc = crc16_fold(crc, fb[k]);
            end
            fb[span - 2] = crc[7:0];
            fb[span - 1] = crc[15:8];
            // One field in five frames is damaged: length, address,
            // function, CRC low or CRC high byte.
            broken = clean ? 99 : $urandom_range(0, 24);
            if (broken < 5) begin
                n = (broken < 3) ? broken : span - 5 + broken;
                fb[n] = fb[n] ^ 8'($urandom_range(1, 255));
            end
            for (int k = 0; k < span; k++) begin
                send_byte(fb[k], k == 0, 1'b0, ST_OK);
            end
            counted_bytes += span;
        end
    endtask

    initial begin
        t_stim_row   row;
        logic [7:0]  rx;
        logic [15:0] gen_crc;
        logic [7:0]  new_len;
        logic [7:0]  new_addr;
        logic [7:0]  new_func;
        int          phase;
        int          k;

        // Every input is known from time zero, while reset is held low.
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_rx_byte = 8'd0;
        i_frame_first = 1'b0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_FRAME_LENGTH;
        i_cfg_data = 8'd0;
        pin_valid = 1'b0;
        pin_status = ST_OK;
        in_idle_pct = 0;
        out_stall_pct = 0;
        err_count = 0;
        counted_bytes = 0;
        verdicts_due = 0;
        gen_crc = CRC_INIT;

        // Predictor state after reset.
        cfg_len = 8'd5;
        cfg_addr = 8'd2;
        cfg_func = 8'd0;
        frame_pos = 8'd0;
        frame_crc = CRC_INIT;
        frame_err = ST_OK;
        crc_lo_held = 8'd0;
        frame_closed = 1'b1;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed frames. The CRC bytes are built here as the rows go by.
        for (k = 0; k < STIM_ROWS; k++) begin
            row = STIM_TAB[k];
            if (row.first) gen_crc = CRC_INIT;
            case (row.kind)
                BK_RAW: begin
                    rx = row.rx;
                    gen_crc = crc16_fold(gen_crc, rx);
                end
                BK_CRC_LO:     rx = gen_crc[7:0];
                BK_CRC_HI:     rx = gen_crc[15:8];
                BK_CRC_HI_BAD: rx = gen_crc[15:8] ^ 8'h01;
                default:       rx = row.rx;
            endcase
            send_byte(rx, row.first, row.pin, row.status);
        end

        // Random phases. The first three pin the register extremes and a
        // short length; later phases draw mostly short frames.
        phase = 0;
        while (counted_bytes < 650 || verdicts_due < 40) begin
            wait_idle();
            case (phase)
                0: begin
                    new_len = 8'd255;
                    new_addr = 8'hFF;
                    new_func = 8'hFF;
                end
                1: begin
                    new_len = 8'd0;
                    new_addr = 8'h00;
                    new_func = 8'h00;
                end
                default: begin
                    k = $urandom_range(99);
                    if (phase == 2 || k < 15) begin
                        new_len = 8'($urandom_range(0, 4));
                    end else if (k < 85) begin
                        new_len = 8'($urandom_range(5, 12));
                    end else begin
                        new_len = 8'($urandom_range(13, 40));
                    end
                    new_addr = 8'($urandom_range(255));
                    new_func = 8'($urandom_range(255));
                end
            endcase
            write_reg(CFG_STATION_ADDRESS, new_addr);
            if (phase == 1 || $urandom_range(3) == 0) begin
                write_reg(CFG_IDX_SPARE, 8'($urandom_range(255)));
            end
            write_reg(CFG_FRAME_LENGTH, new_len);
            write_reg(CFG_EXPECTED_FUNCTION, new_func);

            // Idling patterns rotate: none, sender, receiver, both.
            case (phase % 4)
                0: begin
                    in_idle_pct = 0;
                    out_stall_pct = 0;
                end
                1: begin
                    in_idle_pct = 45;
                    out_stall_pct = 0;
                end
                2: begin
                    in_idle_pct = 0;
                    out_stall_pct = 45;
                end
                default: begin
                    in_idle_pct = 26;
                    out_stall_pct = 26;
                end
            endcase

            // The longest frame is sent once, well-formed.
            if (cfg_len == 8'd255) begin
                send_frame(1'b1);
            end else begin
                repeat (8) send_frame(1'b0);
            end
            phase++;
        end

        // Drain the pending verdicts, within a bound.
        @(negedge i_clk);
        i_in_valid = 1'b0;
        for (k = 0; k < 5000 && verdict_q.size() != 0; k++) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (verdict_q.size() != 0) begin
            report_mismatch("verdicts never delivered", 16'(verdict_q.size()), 16'd0);
        end

        if (err_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
